@@ rtl/prld_pkg.sv @@
// ----------------------------------------------------------------------------
// prld_pkg
// shared types and constants for the picture run-length decoder
// ----------------------------------------------------------------------------
package prld_pkg;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_BASE_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_PICTURE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_PICTURE_HEIGHT = 2'd2;
  localparam logic [1:0] REG_INVERT_OUTPUT  = 2'd3;

  localparam logic [1:0] RUN_MARK   = 2'b11;
  localparam logic [6:0] MAX_WIDTH  = 7'd64;
  localparam logic [7:0] INVERT_ALL = 8'hFF;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       first_of_picture;
  } code_t;

  typedef struct packed {
    logic [7:0]  pixel_byte;
    logic [15:0] display_address;
    logic        row_end;
    logic        picture_end;
    logic        last_of_item;
  } pixel_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/picture_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// picture_run_length_decoder
// expands run-length code bytes into display bytes with screen addresses
// ----------------------------------------------------------------------------
// One code byte is taken at a time, after which a single emit sequencer
// produces its display bytes one per cycle (1 to 64 for a zero run, 1 to 3
// for a data code) while the output side keeps taking them; code_stall stays
// high until the last byte is loaded into the output register. An item that
// arrives after the picture is complete, with no first_of_picture, gives no
// bytes. Output stalls hold the sequencer.
module picture_run_length_decoder #(
  parameter int unsigned ROW_STRIDE = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         code_valid,
  output logic                         code_stall,
  input  prld_pkg::code_t              code,
  output logic                         pixel_valid,
  input  logic                         pixel_stall,
  output prld_pkg::pixel_t             pixel,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prld_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [15:0] base_address;
  logic [6:0]  picture_width;
  logic [7:0]  picture_height;
  logic        invert_output;

  prld_pkg::state_t state, state_next;
  logic [6:0]  remaining, remaining_next;
  logic [5:0]  last_value, last_value_next;
  logic [5:0]  column_count, column_count_next;
  logic [7:0]  row_count, row_count_next;
  logic [15:0] row_start_address, row_start_address_next;
  logic        picture_done, picture_done_next;
  logic        pixel_valid_next;
  prld_pkg::pixel_t pixel_next;

  logic        code_accept;
  logic        slot_free;
  logic        emit;
  logic        is_run;
  logic        at_row_end;
  logic        at_pic_end;
  logic        item_last;
  logic [5:0]  width_m1;
  logic [7:0]  height_m1;
  logic [7:0]  byte_value;
  logic        cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      picture_width  <= 7'd1;
      picture_height <= 8'd1;
      invert_output  <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        prld_pkg::REG_BASE_ADDRESS:   base_address   <= pwdata[15:0];
        prld_pkg::REG_PICTURE_WIDTH:  picture_width  <= pwdata[6:0];
        prld_pkg::REG_PICTURE_HEIGHT: picture_height <= pwdata[7:0];
        prld_pkg::REG_INVERT_OUTPUT:  invert_output  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      prld_pkg::REG_BASE_ADDRESS:   prdata = {16'd0, base_address};
      prld_pkg::REG_PICTURE_WIDTH:  prdata = {25'd0, picture_width};
      prld_pkg::REG_PICTURE_HEIGHT: prdata = {24'd0, picture_height};
      prld_pkg::REG_INVERT_OUTPUT:  prdata = {31'd0, invert_output};
      default:                      prdata = '0;
    endcase
  end

  // effective size limits
  always_comb begin
    if (picture_width == 7'd0) begin
      width_m1 = 6'd0;
    end else if (picture_width > prld_pkg::MAX_WIDTH) begin
      width_m1 = 6'd63;
    end else begin
      width_m1 = 6'(picture_width - 7'd1);
    end
    height_m1 = (picture_height == 8'd0) ? 8'd0 : picture_height - 8'd1;
  end

  assign code_stall  = (state != prld_pkg::ST_IDLE);
  assign code_accept = code_valid && !code_stall;
  assign is_run      = (code.code_byte[7:6] == prld_pkg::RUN_MARK);
  assign slot_free   = !pixel_valid || !pixel_stall;
  assign emit        = (state == prld_pkg::ST_EMIT) && !picture_done && slot_free;
  assign at_row_end  = (column_count >= width_m1);
  assign at_pic_end  = at_row_end && (row_count >= height_m1);
  assign item_last   = (remaining == 7'd1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      prld_pkg::ST_IDLE: begin
        if (code_accept) state_next = prld_pkg::ST_EMIT;
      end
      prld_pkg::ST_EMIT: begin
        if (picture_done) begin
          state_next = prld_pkg::ST_IDLE;
        end else if (emit && (item_last || at_pic_end)) begin
          state_next = prld_pkg::ST_IDLE;
        end
      end
      default: state_next = prld_pkg::ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_comb begin
    remaining_next         = remaining;
    last_value_next        = last_value;
    column_count_next      = column_count;
    row_count_next         = row_count;
    row_start_address_next = row_start_address;
    picture_done_next      = picture_done;
    pixel_next             = pixel;
    byte_value             = item_last ? {2'b00, last_value} : 8'd0;
    if (invert_output) byte_value = byte_value ^ prld_pkg::INVERT_ALL;

    if (code_accept) begin
      if (code.first_of_picture) begin
        column_count_next      = '0;
        row_count_next         = '0;
        row_start_address_next = base_address;
        picture_done_next      = 1'b0;
      end
      if (is_run) begin
        remaining_next  = {1'b0, code.code_byte[5:0]} + 7'd1;
        last_value_next = '0;
      end else begin
        remaining_next  = {5'd0, code.code_byte[7:6]} + 7'd1;
        last_value_next = code.code_byte[5:0];
      end
    end

    if (emit) begin
      pixel_next.pixel_byte      = byte_value;
      pixel_next.display_address = row_start_address + {10'd0, column_count};
      pixel_next.row_end         = at_row_end;
      pixel_next.picture_end     = at_pic_end;
      pixel_next.last_of_item    = item_last || at_pic_end;
      remaining_next             = remaining - 7'd1;
      if (at_row_end) begin
        column_count_next      = '0;
        row_count_next         = row_count + 8'd1;
        row_start_address_next = row_start_address + 16'(ROW_STRIDE);
      end else begin
        column_count_next = column_count + 6'd1;
      end
      if (at_pic_end) picture_done_next = 1'b1;
    end

    if (emit) begin
      pixel_valid_next = 1'b1;
    end else if (pixel_stall) begin
      pixel_valid_next = pixel_valid;
    end else begin
      pixel_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= prld_pkg::ST_IDLE;
      remaining         <= '0;
      column_count      <= '0;
      row_count         <= '0;
      row_start_address <= '0;
      picture_done      <= 1'b0;
      pixel_valid       <= 1'b0;
    end else begin
      state             <= state_next;
      remaining         <= remaining_next;
      column_count      <= column_count_next;
      row_count         <= row_count_next;
      row_start_address <= row_start_address_next;
      picture_done      <= picture_done_next;
      pixel_valid       <= pixel_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    last_value <= last_value_next;
    pixel      <= pixel_next;
  end

endmodule

@@ rtl/prld_checker.sv @@
// ----------------------------------------------------------------------------
// prld_checker
// port-level checks for the picture run-length decoder
// ----------------------------------------------------------------------------
module prld_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        code_valid,
  input logic                        code_stall,
  input logic                        pixel_valid,
  input logic                        pixel_stall,
  input prld_pkg::pixel_t            pixel,
  input logic                        pready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
    else $error("stalled result changed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_stall |=> code_stall)
    else $error("request taken while busy");

  // picture end closes the row and the request
  a_end: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.picture_end |-> pixel.row_end && pixel.last_of_item)
    else $error("picture end without row end or last mark");

  // more results pending keeps the input stalled
  a_pending: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel.last_of_item |-> code_stall)
    else $error("request taken before results finished");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind picture_run_length_decoder prld_checker u_prld_checker (
  .clk         (clk),
  .rst         (rst),
  .code_valid  (code_valid),
  .code_stall  (code_stall),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel       (pixel),
  .pready      (pready)
);

@@ tb/sv/tb_picture_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_picture_run_length_decoder
// self-checking bench for the picture run-length decoder
// ----------------------------------------------------------------------------
// Code bytes go in over the valid/stall request channel. Each accepted request
// is expanded by a local model of the decoder (row and column position, row
// start address, picture done, plus its own copy of the four registers) into
// the display bytes it should produce. Every accepted output byte is then
// compared field by field with the oldest one waiting. A short table of
// directed requests and register writes covers the corners: no restart after
// reset, overflow past the last byte, row address wrap, inversion, out of
// range sizes and a size change mid picture. Random pictures follow, each
// with its own register settings, with random idle bursts on both sides and
// a quiet stretch at the end.
// ----------------------------------------------------------------------------
module tb_picture_run_length_decoder;

  localparam int ROW_STRIDE    = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 116;
  localparam int QUIET_FROM    = 95;

  typedef struct packed {
    logic              is_reg;
    logic [1:0]        reg_idx;
    logic [31:0]       value;
    prld_pkg::code_t   item;
    logic              typed;
    prld_pkg::pixel_t  result;
  } step_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        code_valid = 1'b0;
  logic                        code_stall;
  prld_pkg::code_t             code = '0;
  logic                        pixel_valid;
  logic                        pixel_stall = 1'b0;
  prld_pkg::pixel_t            pixel;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [prld_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // decoder model registers and position
  logic [15:0]         base_cfg = '0;
  logic [6:0]          width_cfg = 7'd1;
  logic [7:0]          height_cfg = 8'd1;
  logic                invert_cfg = 1'b0;
  logic [5:0]          column_pos = '0;
  logic [7:0]          row_pos = '0;
  logic [15:0]         row_start = '0;
  logic                picture_done = 1'b0;

  prld_pkg::pixel_t    decoded_pixels[$];
  prld_pkg::pixel_t    expected_pixels[$];
  step_t               script[$];
  int                  failures = 0;
  int                  stall_left = 0;
  bit                  quiet = 1'b0;

  picture_run_length_decoder #(
    .ROW_STRIDE(ROW_STRIDE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code(code),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic void place_pixel(logic [7:0] value);
    logic [6:0]       w;
    logic [7:0]       h;
    logic             at_row_end;
    logic             at_pic_end;
    prld_pkg::pixel_t p;
    if (picture_done) return;
    w = (width_cfg == '0) ? 7'd1 :
        ((width_cfg > prld_pkg::MAX_WIDTH) ? prld_pkg::MAX_WIDTH : width_cfg);
    h = (height_cfg == '0) ? 8'd1 : height_cfg;
    at_row_end = {1'b0, column_pos} >= w - 7'd1;
    at_pic_end = at_row_end && (row_pos >= h - 8'd1);
    p.pixel_byte = invert_cfg ? (value ^ prld_pkg::INVERT_ALL) : value;
    p.display_address = row_start + 16'(column_pos);
    p.row_end = at_row_end;
    p.picture_end = at_pic_end;
    p.last_of_item = 1'b0;
    decoded_pixels.push_back(p);
    if (at_row_end) begin
      column_pos = '0;
      row_pos = row_pos + 8'd1;
      row_start = 16'(row_start + ROW_STRIDE);
    end else begin
      column_pos = column_pos + 6'd1;
    end
    if (at_pic_end) picture_done = 1'b1;
  endfunction

  function automatic void decode_code(prld_pkg::code_t c);
    int zeros;
    decoded_pixels.delete();
    if (c.first_of_picture) begin
      column_pos = '0;
      row_pos = '0;
      row_start = base_cfg;
      picture_done = 1'b0;
    end
    if (c.code_byte[7:6] == prld_pkg::RUN_MARK) begin
      zeros = int'(c.code_byte[5:0]) + 1;
      for (int i = 0; i < zeros; i++) place_pixel(8'h00);
    end else begin
      zeros = int'(c.code_byte[7:6]);
      for (int i = 0; i < zeros; i++) place_pixel(8'h00);
      place_pixel({2'b00, c.code_byte[5:0]});
    end
    if (decoded_pixels.size() > 0)
      decoded_pixels[decoded_pixels.size() - 1].last_of_item = 1'b1;
  endfunction

  function automatic void set_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      prld_pkg::REG_BASE_ADDRESS:   base_cfg = value[15:0];
      prld_pkg::REG_PICTURE_WIDTH:  width_cfg = value[6:0];
      prld_pkg::REG_PICTURE_HEIGHT: height_cfg = value[7:0];
      prld_pkg::REG_INVERT_OUTPUT:  invert_cfg = value[0];
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic step_t code_row(logic [7:0] b, logic f);
    step_t s;
    s = '0;
    s.item.code_byte = b;
    s.item.first_of_picture = f;
    return s;
  endfunction

  function automatic step_t typed_row(logic [7:0] b, logic f, prld_pkg::pixel_t r);
    step_t s;
    s = code_row(b, f);
    s.typed = 1'b1;
    s.result = r;
    return s;
  endfunction

  function automatic step_t reg_row(logic [1:0] idx, logic [31:0] value);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.value = value;
    return s;
  endfunction

  function automatic logic [7:0] random_code();
    case ($urandom_range(0, 9))
      0, 1, 2: return {prld_pkg::RUN_MARK, 3'b000, 3'($urandom_range(0, 7))};
      3:       return {prld_pkg::RUN_MARK, 6'($urandom_range(0, 63))};
      default: return 8'($urandom_range(0, 8'hBF));
    endcase
  endfunction

  task automatic send_code(input prld_pkg::code_t c, input logic typed,
                           input prld_pkg::pixel_t typed_result);
    code_valid <= 1'b1;
    code <= c;
    @(posedge clk);
    while (code_stall) @(posedge clk);
    decode_code(c);
    if (typed) expected_pixels.push_back(typed_result);
    else foreach (decoded_pixels[i]) expected_pixels.push_back(decoded_pixels[i]);
  endtask

  task automatic idle_gap(input int cycles);
    code_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_pixels();
    code_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // output side: random stall bursts and checking
  always @(posedge clk) begin
    prld_pkg::pixel_t want;
    if (!rst && pixel_valid && !pixel_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel: unexpected output, address %0h", pixel.display_address);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("pixel_byte", want.pixel_byte, pixel.pixel_byte);
        compare_field("display_address", want.display_address, pixel.display_address);
        compare_field("row_end", want.row_end, pixel.row_end);
        compare_field("picture_end", want.picture_end, pixel.picture_end);
        compare_field("last_of_item", want.last_of_item, pixel.last_of_item);
      end
    end
    if (rst) begin
      pixel_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      pixel_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      pixel_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      pixel_stall <= 1'b0;
    end
  end

  initial begin
    #4000000;
    $display("tb_picture_run_length_decoder: FAIL");
    $finish;
  end

  initial begin
    prld_pkg::code_t c;
    int              random_items;
    int              n_codes;
    logic [31:0]     width_v;
    logic [31:0]     height_v;

    // reset values, no restart yet
    script.push_back(typed_row(8'h2A, 1'b0,
                               prld_pkg::pixel_t'{8'h2A, 16'h0000, 1'b1, 1'b1, 1'b1}));
    script.push_back(code_row(8'h00, 1'b0));
    script.push_back(typed_row(8'h3F, 1'b1,
                               prld_pkg::pixel_t'{8'h3F, 16'h0000, 1'b1, 1'b1, 1'b1}));
    // small picture near the top of memory, row address wraps
    script.push_back(reg_row(prld_pkg::REG_BASE_ADDRESS, 32'h0000_FFC0));
    script.push_back(reg_row(prld_pkg::REG_PICTURE_WIDTH, 32'd3));
    script.push_back(reg_row(prld_pkg::REG_PICTURE_HEIGHT, 32'd2));
    script.push_back(reg_row(prld_pkg::REG_INVERT_OUTPUT, 32'd0));
    script.push_back(code_row(8'h40, 1'b1));
    script.push_back(code_row(8'hFF, 1'b0));
    script.push_back(code_row(8'h81, 1'b1));
    script.push_back(code_row(8'hC0, 1'b0));
    script.push_back(reg_row(prld_pkg::REG_INVERT_OUTPUT, 32'd1));
    script.push_back(code_row(8'h15, 1'b0));
    // zero sizes count as one
    script.push_back(reg_row(prld_pkg::REG_PICTURE_WIDTH, 32'd0));
    script.push_back(reg_row(prld_pkg::REG_PICTURE_HEIGHT, 32'd0));
    script.push_back(reg_row(prld_pkg::REG_BASE_ADDRESS, 32'h0000_1234));
    script.push_back(typed_row(8'h3F, 1'b1,
                               prld_pkg::pixel_t'{8'hC0, 16'h1234, 1'b1, 1'b1, 1'b1}));
    // widest picture, width above the maximum
    script.push_back(reg_row(prld_pkg::REG_PICTURE_WIDTH, 32'd127));
    script.push_back(reg_row(prld_pkg::REG_PICTURE_HEIGHT, 32'd255));
    script.push_back(reg_row(prld_pkg::REG_INVERT_OUTPUT, 32'd0));
    script.push_back(reg_row(prld_pkg::REG_BASE_ADDRESS, 32'd0));
    script.push_back(code_row(8'hFF, 1'b1));
    script.push_back(code_row(8'hC3, 1'b0));
    // width shrinks below the current column
    script.push_back(reg_row(prld_pkg::REG_PICTURE_WIDTH, 32'd2));
    script.push_back(code_row(8'h00, 1'b0));
    script.push_back(reg_row(prld_pkg::REG_PICTURE_WIDTH, 32'd64));
    script.push_back(code_row(8'hBF, 1'b0));
    script.push_back(code_row(8'h7F, 1'b1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        drain_pixels();
        write_register(script[i].reg_idx, script[i].value);
      end else begin
        send_code(script[i].item, script[i].typed, script[i].result);
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 14));
      end
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain_pixels();
      quiet = (random_items >= QUIET_FROM) || ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       width_v = $urandom_range(33, 64);
        1:       width_v = $urandom_range(0, 1) ? 32'd0 : $urandom_range(65, 127);
        default: width_v = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       height_v = 32'd0;
        1:       height_v = 32'd255;
        default: height_v = $urandom_range(1, 4);
      endcase
      write_register(prld_pkg::REG_BASE_ADDRESS, $urandom());
      write_register(prld_pkg::REG_PICTURE_WIDTH, width_v);
      write_register(prld_pkg::REG_PICTURE_HEIGHT, height_v);
      write_register(prld_pkg::REG_INVERT_OUTPUT, $urandom_range(0, 1));
      n_codes = $urandom_range(2, 10);
      for (int k = 0; k < n_codes; k++) begin
        c.code_byte = random_code();
        if (k == 0) c.first_of_picture = ($urandom_range(0, 7) != 0);
        else c.first_of_picture = ($urandom_range(0, 15) == 0);
        send_code(c, 1'b0, prld_pkg::pixel_t'('0));
        random_items++;
        if (k == n_codes / 2 && $urandom_range(0, 3) == 0) drain_pixels();
        else if (!quiet && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 14));
      end
    end

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) $display("tb_picture_run_length_decoder: PASS");
    else $display("tb_picture_run_length_decoder: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/prld_pkg.sv
rtl/picture_run_length_decoder.sv
rtl/prld_checker.sv
tb/sv/tb_picture_run_length_decoder.sv
